>>> src/aabb_pkg.sv
// Shared types and constants for the box overlap scan.
package aabb_pkg;

  localparam int DEF_MAX_ENTITIES = 1024;
  localparam int DEF_COORD_WIDTH  = 48;

  localparam int LANES      = 8;
  localparam int LANE_W     = 3;
  localparam int WORD_BITS  = 64;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int WIDX_W     = 4;
  localparam int SCAN_ROW_W = 9;
  localparam int AXES       = 6;
  localparam int APB_W      = 32;
  localparam int PADDR_W    = 3;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_BOX_COUNT = 1'b0;

  typedef struct packed {
    logic                  valid;
    logic [SCAN_ROW_W-1:0] row;
    logic                  last;
  } tok_t;

endpackage

>>> src/aabb_overlap_bitmap_scan.sv
// Top level of the box overlap scan: configuration, issue control, lane chain and word packing.
// A load item never raises busy; busy stays low.
// A query over n boxes (R = ceil(n/8) rows) keeps busy high until the word marked last is shown.
// Eight lanes, one box each per cycle; the first word, of k rows, shows once its last row has passed all eight lanes.
// With a count of zero the single empty word appears in the cycle after accept.
// Synchronous reset clears control state and the box count; the box store holds no reset value.
module aabb_overlap_bitmap_scan #(
  parameter int MAX_ENTITIES = aabb_pkg::DEF_MAX_ENTITIES,
  parameter int COORD_WIDTH  = aabb_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [aabb_pkg::IDX_W-1:0]    entity_index,
  input  logic signed [COORD_WIDTH-1:0] min_x,
  input  logic signed [COORD_WIDTH-1:0] min_y,
  input  logic signed [COORD_WIDTH-1:0] min_z,
  input  logic signed [COORD_WIDTH-1:0] max_x,
  input  logic signed [COORD_WIDTH-1:0] max_y,
  input  logic signed [COORD_WIDTH-1:0] max_z,
  output logic                          hit_valid,
  output logic [aabb_pkg::WORD_BITS-1:0] hit_word,
  output logic [aabb_pkg::WIDX_W-1:0]   word_index,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aabb_pkg::PADDR_W-1:0]  paddr,
  input  logic [aabb_pkg::APB_W-1:0]    pwdata,
  output logic [aabb_pkg::APB_W-1:0]    prdata,
  output logic                          pready
);
  import aabb_pkg::*;

  localparam int ROWS  = (MAX_ENTITIES + LANES - 1) / LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EXT_W = (ROW_W + LANE_W > IDX_W) ? ROW_W + LANE_W : IDX_W;
  localparam int BOX_W = AXES * COORD_WIDTH;

  logic [CNT_W-1:0]      box_count;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_w;
  logic [CNT_W:0]        cnt_round;
  logic [SCAN_ROW_W-1:0] rows_w;
  logic [SCAN_ROW_W-1:0] rows_last;
  logic [SCAN_ROW_W-1:0] issue_row;
  logic                  issuing;
  logic [BOX_W-1:0]      qbox;
  logic [BOX_W-1:0]      in_box;
  logic [EXT_W-1:0]      idx_ext;
  logic                  accept;
  logic                  wr_en;
  logic [WORD_BITS-1:0]  acc;
  logic [WORD_BITS-1:0]  acc_next;
  logic [LANE_W-1:0]     pos;
  logic                  emit;

  tok_t             tok_c  [LANES+1];
  logic [LANES-1:0] hits_c [LANES+1];

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_BOX_COUNT) ? APB_W'(box_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[PADDR_W-1] == REG_BOX_COUNT) begin
      box_count <= pwdata[CNT_W-1:0];
    end
  end

  assign accept  = start && !busy;
  assign in_box  = {max_z, max_y, max_x, min_z, min_y, min_x};
  assign idx_ext = EXT_W'(entity_index);
  assign wr_en   = accept && kind == KIND_LOAD && 32'(entity_index) < 32'(MAX_ENTITIES);

  assign cnt_w     = (32'(box_count) > 32'(MAX_ENTITIES)) ? CNT_W'(MAX_ENTITIES)
                                                          : box_count;
  assign cnt_round = {1'b0, cnt_w} + (CNT_W+1)'(LANES - 1);
  assign rows_w    = SCAN_ROW_W'(cnt_round >> LANE_W);

  assign tok_c[0].valid = issuing;
  assign tok_c[0].row   = issue_row;
  assign tok_c[0].last  = issue_row == rows_last;
  assign hits_c[0]      = '0;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    aabb_cell #(
      .LANE  (i),
      .ROWS  (ROWS),
      .ROW_W (ROW_W),
      .CW    (COORD_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_lane  (idx_ext[LANE_W-1:0]),
      .wr_row   (idx_ext[ROW_W+LANE_W-1:LANE_W]),
      .wr_data  (in_box),
      .qbox     (qbox),
      .cnt      (cnt),
      .tok_in   (tok_c[i]),
      .hits_in  (hits_c[i]),
      .tok_out  (tok_c[i+1]),
      .hits_out (hits_c[i+1])
    );
  end

  assign pos      = tok_c[LANES].row[LANE_W-1:0];
  assign acc_next = ((pos == '0) ? '0 : acc)
                  | (WORD_BITS'(hits_c[LANES]) << {pos, 3'b000});
  assign emit     = tok_c[LANES].valid && (pos == LANE_W'(LANES - 1) || tok_c[LANES].last);

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_QUERY) begin
      qbox      <= in_box;
      cnt       <= cnt_w;
      rows_last <= rows_w - SCAN_ROW_W'(1);
    end
    if (tok_c[LANES].valid) begin
      acc <= acc_next;
    end
    if (rst) begin
      busy       <= 1'b0;
      issuing    <= 1'b0;
      issue_row  <= '0;
      hit_valid  <= 1'b0;
      hit_word   <= '0;
      word_index <= '0;
      last       <= 1'b0;
    end else begin
      hit_valid <= 1'b0;
      if (accept && kind == KIND_QUERY) begin
        if (cnt_w == '0) begin
          hit_valid  <= 1'b1;
          hit_word   <= '0;
          word_index <= '0;
          last       <= 1'b1;
        end else begin
          busy      <= 1'b1;
          issuing   <= 1'b1;
          issue_row <= '0;
        end
      end
      if (issuing) begin
        issue_row <= issue_row + SCAN_ROW_W'(1);
        if (tok_c[0].last) begin
          issuing <= 1'b0;
        end
      end
      if (emit) begin
        hit_valid  <= 1'b1;
        hit_word   <= acc_next;
        word_index <= WIDX_W'(tok_c[LANES].row >> LANE_W);
        last       <= tok_c[LANES].last;
        if (tok_c[LANES].last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    hit_valid && last |-> !busy)
    else $error("final word shown while still busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !last |-> busy)
    else $error("intermediate word shown outside a scan");

  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    issuing |-> busy)
    else $error("rows issued while not busy");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_LOAD |=> !hit_valid)
    else $error("load item produced a result");

endmodule

>>> src/aabb_cell.sv
// One lane of the scan chain: a slice of the box store, a compare and a hand-on stage.
module aabb_cell #(
  parameter int LANE  = 0,
  parameter int ROWS  = 128,
  parameter int ROW_W = 7,
  parameter int CW    = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [aabb_pkg::LANE_W-1:0] wr_lane,
  input  logic [ROW_W-1:0]            wr_row,
  input  logic [6*CW-1:0]             wr_data,
  input  logic [6*CW-1:0]             qbox,
  input  logic [aabb_pkg::CNT_W-1:0]  cnt,
  input  aabb_pkg::tok_t              tok_in,
  input  logic [aabb_pkg::LANES-1:0]  hits_in,
  output aabb_pkg::tok_t              tok_out,
  output logic [aabb_pkg::LANES-1:0]  hits_out
);
  import aabb_pkg::*;

  logic [AXES*CW-1:0] mem [ROWS];
  logic [AXES*CW-1:0] rd_data;
  tok_t               tok_a;
  logic [LANES-1:0]   hits_a;
  logic               in_range;
  logic               hit;

  always_ff @(posedge clk) begin
    if (wr_en && wr_lane == LANE_W'(LANE)) begin
      mem[wr_row] <= wr_data;
    end
    rd_data <= mem[ROW_W'(tok_in.row)];
  end

  assign in_range = {tok_a.row, LANE_W'(LANE)} < {1'b0, cnt};

  always_comb begin
    hit = in_range;
    for (int a = 0; a < 3; a++) begin
      hit = hit
          && ($signed(qbox[a*CW +: CW]) < $signed(rd_data[(a+3)*CW +: CW]))
          && ($signed(qbox[(a+3)*CW +: CW]) > $signed(rd_data[a*CW +: CW]));
    end
  end

  always_ff @(posedge clk) begin
    hits_a   <= hits_in;
    hits_out <= hits_a | (LANES'(hit) << LANE);
    if (rst) begin
      tok_a   <= '0;
      tok_out <= '0;
    end else begin
      tok_a   <= tok_in;
      tok_out <= tok_a;
    end
  end

endmodule
